// File: rtl/core/rffe_pkg.sv
`default_nettype none
package rffe_pkg;

   // parser phase of the front end
   typedef enum logic [1:0] {
      PHASE_HUNT,
      PHASE_HEADER,
      PHASE_PAYLOAD
   } phase_type;

   // recognized frame layouts
   typedef enum logic [2:0] {
      FRAME_GAME_STATUS,
      FRAME_ROBOT_HP,
      FRAME_WARNING,
      FRAME_ROBOT_STATUS,
      FRAME_POWER_HEAT,
      FRAME_SHOOT,
      FRAME_NONE
   } frame_type;

   // how a completed payload segment is turned into a field update
   typedef enum logic [2:0] {
      KIND_SKIP,
      KIND_PLAIN,
      KIND_STAGE,
      KIND_WARN,
      KIND_LAUNCH,
      KIND_ROBOT,
      KIND_SET_A,
      KIND_SET_B
   } kind_type;

   // field numbering on the result port
   localparam logic [4:0] FID_NONE             = 5'd0;
   localparam logic [4:0] FID_STAGE            = 5'd0;
   localparam logic [4:0] FID_REMAIN_TIME      = 5'd1;
   localparam logic [4:0] FID_WARNING          = 5'd2;
   localparam logic [4:0] FID_BLUE_SENTRY_HP   = 5'd3;
   localparam logic [4:0] FID_RED_SENTRY_HP    = 5'd4;
   localparam logic [4:0] FID_FOUL_ROBOT       = 5'd5;
   localparam logic [4:0] FID_ROBOT_ID         = 5'd6;
   localparam logic [4:0] FID_ROBOT_LEVEL      = 5'd7;
   localparam logic [4:0] FID_ROBOT_HP         = 5'd8;
   localparam logic [4:0] FID_COOLING          = 5'd9;
   localparam logic [4:0] FID_HEAT_LIMIT       = 5'd10;
   localparam logic [4:0] FID_ALT_COOLING      = 5'd11;
   localparam logic [4:0] FID_ALT_HEAT_LIMIT   = 5'd12;
   localparam logic [4:0] FID_ALT_SPEED_LIMIT  = 5'd13;
   localparam logic [4:0] FID_CHASSIS_VOLTAGE  = 5'd14;
   localparam logic [4:0] FID_CHASSIS_CURRENT  = 5'd15;
   localparam logic [4:0] FID_POWER_LIMIT      = 5'd16;
   localparam logic [4:0] FID_CHASSIS_POWER    = 5'd17;
   localparam logic [4:0] FID_BARREL_HEAT      = 5'd18;
   localparam logic [4:0] FID_ALT_BARREL_HEAT  = 5'd19;
   localparam logic [4:0] FID_LAUNCH_ID        = 5'd20;
   localparam logic [4:0] FID_LAUNCH_SPEED     = 5'd21;
   localparam logic [4:0] FID_LAUNCH_FREQ      = 5'd22;
   localparam logic [4:0] FID_SPEED_LIMIT      = 5'd23;

   // one classified payload byte, front end to back end
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       first;
      logic       seg_end;
      logic       frame_last;
      logic [4:0] fid;
      kind_type   kind;
   } item_type;

endpackage
`default_nettype wire

// File: rtl/core/referee_frame_field_extractor.sv
`default_nettype none
// Referee frame field extractor: takes received serial bytes one word per cycle,
// hunts for start byte 0xA5, skips length, sequence and CRC, reads the 16-bit
// command id and walks the payload of commands 1, 3, 260, 201, 514 and 519.
// Each completed field comes out as one result word (field_id, field_value,
// field_valid); the last payload byte of a recognized frame always yields a word
// with frame_end set. Length, CRC and tail are not checked. A byte is accepted
// every cycle while the classify-to-decode queue (QUEUE_DEPTH words) has room;
// with the result register free, an accepted payload byte is written to the queue and
// from there into the result register, and the queue only fills when the result side stalls.
module referee_frame_field_extractor #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [4:0]       rsp_field_id,
   output logic [31:0]      rsp_field_value,
   output logic             rsp_field_valid,
   output logic             rsp_frame_end
);
   import rffe_pkg::*;

   item_type push_item, pop_item;
   logic     q_push, q_full, q_pop, q_empty;

   // header parser and byte classifier
   rffe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   // decoupling queue
   rffe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   // value assembly and field decode
   rffe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_item          (pop_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_field_id    (rsp_field_id),
      .rsp_field_value (rsp_field_value),
      .rsp_field_valid (rsp_field_valid),
      .rsp_frame_end   (rsp_frame_end)
   );

`ifndef SYNTHESIS
   // every result word carries an update or closes a frame
   a_rsp_meaningful: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_field_valid || rsp_frame_end))
      else $error("result word with neither update nor frame end");

   // a frame-end word without update is all zero
   a_rsp_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_field_valid) |-> (rsp_field_id == FID_NONE && rsp_field_value == 32'd0))
      else $error("empty result word carries data");

   // front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("push into full queue");

   // launch id is always 1 to 3
   a_launch_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_field_valid && rsp_field_id == FID_LAUNCH_ID) |->
      (rsp_field_value == 32'd1 || rsp_field_value == 32'd2 || rsp_field_value == 32'd3))
      else $error("launch id out of range");
`endif

endmodule
`default_nettype wire

// File: rtl/core/rffe_front.sv
`default_nettype none
module rffe_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_rx_byte,
   input  wire logic              q_full,
   output logic                   q_push,
   output rffe_pkg::item_type     q_item
);
   import rffe_pkg::*;

   localparam logic [7:0]  StartByte      = 8'hA5;
   localparam logic [2:0]  HdrCmdHigh     = 3'd4;
   localparam logic [2:0]  HdrCmdLow      = 3'd5;
   localparam logic [15:0] CmdGameStatus  = 16'd1;
   localparam logic [15:0] CmdRobotHp     = 16'd3;
   localparam logic [15:0] CmdWarning     = 16'd260;
   localparam logic [15:0] CmdRobotStatus = 16'd201;
   localparam logic [15:0] CmdPowerHeat   = 16'd514;
   localparam logic [15:0] CmdShoot       = 16'd519;

   typedef struct packed {
      logic [4:0] start;
      logic [4:0] len;
      logic [4:0] fid;
      kind_type   kind;
   } seg_desc_type;

   function automatic frame_type find_frame(input logic [15:0] cmd);
      frame_type f;
      case (cmd)
         CmdGameStatus:  f = FRAME_GAME_STATUS;
         CmdRobotHp:     f = FRAME_ROBOT_HP;
         CmdWarning:     f = FRAME_WARNING;
         CmdRobotStatus: f = FRAME_ROBOT_STATUS;
         CmdPowerHeat:   f = FRAME_POWER_HEAT;
         CmdShoot:       f = FRAME_SHOOT;
         default:        f = FRAME_NONE;
      endcase
      return f;
   endfunction

   function automatic logic [4:0] last_offset(input frame_type f);
      logic [4:0] l;
      case (f)
         FRAME_GAME_STATUS:  l = 5'd2;
         FRAME_ROBOT_HP:     l = 5'd27;
         FRAME_WARNING:      l = 5'd1;
         FRAME_ROBOT_STATUS: l = 5'd25;
         FRAME_POWER_HEAT:   l = 5'd15;
         FRAME_SHOOT:        l = 5'd6;
         default:            l = 5'd0;
      endcase
      return l;
   endfunction

   function automatic seg_desc_type mk(input logic [4:0] start, input logic [4:0] len,
                                       input logic [4:0] fid, input kind_type kind);
      seg_desc_type d;
      d.start = start;
      d.len   = len;
      d.fid   = fid;
      d.kind  = kind;
      return d;
   endfunction

   // payload layout of every recognized frame
   function automatic seg_desc_type decode(input frame_type f, input logic [4:0] off);
      seg_desc_type d;
      d = mk(5'd0, 5'd1, FID_NONE, KIND_SKIP);
      case (f)
         FRAME_GAME_STATUS: begin
            case (off) inside
               5'd0:           d = mk(5'd0, 5'd1, FID_STAGE, KIND_STAGE);
               default:        d = mk(5'd1, 5'd2, FID_REMAIN_TIME, KIND_PLAIN);
            endcase
         end
         FRAME_ROBOT_HP: begin
            case (off) inside
               [5'd0:5'd9]:    d = mk(5'd0, 5'd10, FID_NONE, KIND_SKIP);
               [5'd10:5'd11]:  d = mk(5'd10, 5'd2, FID_RED_SENTRY_HP, KIND_PLAIN);
               [5'd12:5'd25]:  d = mk(5'd12, 5'd14, FID_NONE, KIND_SKIP);
               default:        d = mk(5'd26, 5'd2, FID_BLUE_SENTRY_HP, KIND_PLAIN);
            endcase
         end
         FRAME_WARNING: begin
            case (off) inside
               5'd0:           d = mk(5'd0, 5'd1, FID_WARNING, KIND_WARN);
               default:        d = mk(5'd1, 5'd1, FID_FOUL_ROBOT, KIND_PLAIN);
            endcase
         end
         FRAME_ROBOT_STATUS: begin
            case (off) inside
               5'd0:           d = mk(5'd0, 5'd1, FID_ROBOT_ID, KIND_ROBOT);
               5'd1:           d = mk(5'd1, 5'd1, FID_ROBOT_LEVEL, KIND_PLAIN);
               [5'd2:5'd3]:    d = mk(5'd2, 5'd2, FID_ROBOT_HP, KIND_PLAIN);
               [5'd4:5'd5]:    d = mk(5'd4, 5'd2, FID_NONE, KIND_SKIP);
               [5'd6:5'd7]:    d = mk(5'd6, 5'd2, FID_COOLING, KIND_PLAIN);
               [5'd8:5'd9]:    d = mk(5'd8, 5'd2, FID_HEAT_LIMIT, KIND_PLAIN);
               [5'd10:5'd11]:  d = mk(5'd10, 5'd2, FID_SPEED_LIMIT, KIND_PLAIN);
               [5'd12:5'd13]:  d = mk(5'd12, 5'd2, FID_ALT_COOLING, KIND_SET_A);
               [5'd14:5'd15]:  d = mk(5'd14, 5'd2, FID_ALT_HEAT_LIMIT, KIND_SET_A);
               [5'd16:5'd17]:  d = mk(5'd16, 5'd2, FID_ALT_SPEED_LIMIT, KIND_SET_A);
               [5'd18:5'd19]:  d = mk(5'd18, 5'd2, FID_ALT_COOLING, KIND_SET_B);
               [5'd20:5'd21]:  d = mk(5'd20, 5'd2, FID_ALT_HEAT_LIMIT, KIND_SET_B);
               [5'd22:5'd23]:  d = mk(5'd22, 5'd2, FID_ALT_SPEED_LIMIT, KIND_SET_B);
               default:        d = mk(5'd24, 5'd2, FID_POWER_LIMIT, KIND_PLAIN);
            endcase
         end
         FRAME_POWER_HEAT: begin
            case (off) inside
               [5'd0:5'd1]:    d = mk(5'd0, 5'd2, FID_CHASSIS_VOLTAGE, KIND_PLAIN);
               [5'd2:5'd3]:    d = mk(5'd2, 5'd2, FID_CHASSIS_CURRENT, KIND_PLAIN);
               [5'd4:5'd7]:    d = mk(5'd4, 5'd4, FID_CHASSIS_POWER, KIND_PLAIN);
               [5'd8:5'd9]:    d = mk(5'd8, 5'd2, FID_NONE, KIND_SKIP);
               [5'd10:5'd11]:  d = mk(5'd10, 5'd2, FID_BARREL_HEAT, KIND_PLAIN);
               [5'd12:5'd13]:  d = mk(5'd12, 5'd2, FID_ALT_BARREL_HEAT, KIND_SET_A);
               default:        d = mk(5'd14, 5'd2, FID_ALT_BARREL_HEAT, KIND_SET_B);
            endcase
         end
         FRAME_SHOOT: begin
            case (off) inside
               5'd0:           d = mk(5'd0, 5'd1, FID_NONE, KIND_SKIP);
               5'd1:           d = mk(5'd1, 5'd1, FID_LAUNCH_ID, KIND_LAUNCH);
               5'd2:           d = mk(5'd2, 5'd1, FID_LAUNCH_FREQ, KIND_PLAIN);
               default:        d = mk(5'd3, 5'd4, FID_LAUNCH_SPEED, KIND_PLAIN);
            endcase
         end
         default: d = mk(5'd0, 5'd1, FID_NONE, KIND_SKIP);
      endcase
      return d;
   endfunction

   phase_type    phase_ff, phase_in;
   logic [2:0]   hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]   cmd_hi_ff, cmd_hi_in;
   frame_type    frame_ff, frame_in;
   logic [4:0]   offset_ff, offset_in;
   logic         accept;
   logic         at_last;
   frame_type    hdr_frame;
   seg_desc_type seg;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign at_last   = (offset_ff == last_offset(frame_ff));
   assign hdr_frame = find_frame({cmd_hi_ff, req_rx_byte});
   assign seg       = decode(frame_ff, offset_ff);

   // next state of the header and payload walker
   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      cmd_hi_in  = cmd_hi_ff;
      frame_in   = frame_ff;
      offset_in  = offset_ff;
      if (accept) begin
         case (phase_ff)
            PHASE_HUNT: begin
               if (req_rx_byte == StartByte) begin
                  phase_in   = PHASE_HEADER;
                  hdr_cnt_in = 3'd0;
               end
            end
            PHASE_HEADER: begin
               if (hdr_cnt_ff == HdrCmdHigh) begin
                  cmd_hi_in = req_rx_byte;
               end
               if (hdr_cnt_ff == HdrCmdLow) begin
                  hdr_cnt_in = 3'd0;
                  offset_in  = 5'd0;
                  frame_in   = hdr_frame;
                  phase_in   = (hdr_frame != FRAME_NONE) ? PHASE_PAYLOAD : PHASE_HUNT;
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + 3'd1;
               end
            end
            PHASE_PAYLOAD: begin
               if (at_last) begin
                  phase_in  = PHASE_HUNT;
                  offset_in = 5'd0;
               end else begin
                  offset_in = offset_ff + 5'd1;
               end
            end
            default: phase_in = PHASE_HUNT;
         endcase
      end
   end

   // classified payload word toward the queue
   always_comb begin
      q_push             = 1'b0;
      q_item.rx_byte     = req_rx_byte;
      q_item.first       = (offset_ff == seg.start);
      q_item.seg_end     = (offset_ff == 5'(seg.start + seg.len - 5'd1));
      q_item.frame_last  = at_last;
      q_item.fid         = seg.fid;
      q_item.kind        = seg.kind;
      case (phase_ff)
         PHASE_PAYLOAD: q_push = accept;
         default:       q_push = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_HUNT;
         hdr_cnt_ff <= 3'd0;
         cmd_hi_ff  <= 8'd0;
         frame_ff   <= FRAME_NONE;
         offset_ff  <= 5'd0;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         cmd_hi_ff  <= cmd_hi_in;
         frame_ff   <= frame_in;
         offset_ff  <= offset_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/rffe_queue.sv
`default_nettype none
module rffe_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rffe_pkg::item_type push_item,
   output logic                    full,
   input  wire logic               pop,
   output rffe_pkg::item_type      pop_item,
   output logic                    empty
);
   import rffe_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   item_type        entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic            do_push, do_pop;

   assign full     = (count_ff == FullCnt);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/rffe_back.sv
`default_nettype none
module rffe_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  wire rffe_pkg::item_type q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [4:0]              rsp_field_id,
   output logic [31:0]             rsp_field_value,
   output logic                    rsp_field_valid,
   output logic                    rsp_frame_end
);
   import rffe_pkg::*;

   localparam logic [2:0]  StageCount  = 3'd6;
   localparam logic [2:0]  LaunchMin   = 3'd1;
   localparam logic [2:0]  LaunchMax   = 3'd3;
   localparam logic [31:0] WarnYellow  = 32'd1;
   localparam logic [31:0] WarnRed     = 32'd2;
   localparam logic [31:0] WarnFoul    = 32'd3;
   localparam logic [7:0]  CharY       = 8'h59;
   localparam logic [7:0]  CharR       = 8'h52;
   localparam logic [7:0]  CharF       = 8'h46;

   function automatic logic [7:0] stage_char(input logic [2:0] s);
      logic [7:0] c;
      case (s)
         3'd0:    c = 8'h50;
         3'd1:    c = 8'h53;
         3'd2:    c = 8'h49;
         3'd3:    c = 8'h46;
         3'd4:    c = 8'h43;
         3'd5:    c = 8'h52;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic in_set_a(input logic [7:0] id);
      return id inside {8'd3, 8'd4, 8'd5, 8'd7, 8'd103, 8'd104, 8'd105, 8'd107};
   endfunction

   function automatic logic in_set_b(input logic [7:0] id);
      return id inside {8'd1, 8'd101};
   endfunction

   logic [31:0] acc_ff;
   logic [7:0]  robot_ff;
   logic [31:0] acc_val;
   logic        hit;
   logic [31:0] val;
   logic        produce;
   logic        rsp_valid_ff;
   logic [4:0]  fid_ff;
   logic [31:0] value_ff;
   logic        fvalid_ff;
   logic        fend_ff;

   assign q_pop   = !q_empty && (!rsp_valid_ff || rsp_ready);
   assign acc_val = q_item.first ? {24'h0, q_item.rx_byte} : {acc_ff[23:0], q_item.rx_byte};

   // field decode on the closing byte of a segment
   always_comb begin
      hit = 1'b0;
      val = 32'd0;
      if (q_item.seg_end) begin
         case (q_item.kind)
            KIND_PLAIN, KIND_ROBOT: begin
               hit = 1'b1;
               val = acc_val;
            end
            KIND_STAGE: begin
               if (acc_val[2:0] < StageCount) begin
                  hit = 1'b1;
                  val = {24'h0, stage_char(acc_val[2:0])};
               end
            end
            KIND_WARN: begin
               if (acc_val == WarnYellow) begin
                  hit = 1'b1;
                  val = {24'h0, CharY};
               end else if (acc_val == WarnRed) begin
                  hit = 1'b1;
                  val = {24'h0, CharR};
               end else if (acc_val == WarnFoul) begin
                  hit = 1'b1;
                  val = {24'h0, CharF};
               end
            end
            KIND_LAUNCH: begin
               if (acc_val[2:0] >= LaunchMin && acc_val[2:0] <= LaunchMax) begin
                  hit = 1'b1;
                  val = {29'h0, acc_val[2:0]};
               end
            end
            KIND_SET_A: begin
               if (in_set_a(robot_ff)) begin
                  hit = 1'b1;
                  val = acc_val;
               end
            end
            KIND_SET_B: begin
               if (in_set_b(robot_ff)) begin
                  hit = 1'b1;
                  val = acc_val;
               end
            end
            default: hit = 1'b0;
         endcase
      end
   end

   assign produce = hit || q_item.frame_last;

   // accumulator and held robot id
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= 32'd0;
         robot_ff <= 8'd0;
      end else if (q_pop) begin
         acc_ff <= acc_val;
         if (q_item.seg_end && q_item.kind == KIND_ROBOT) begin
            robot_ff <= acc_val[7:0];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop && produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && produce) begin
         fid_ff    <= hit ? q_item.fid : FID_NONE;
         value_ff  <= hit ? val : 32'd0;
         fvalid_ff <= hit;
         fend_ff   <= q_item.frame_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_id    = fid_ff;
   assign rsp_field_value = value_ff;
   assign rsp_field_valid = fvalid_ff;
   assign rsp_frame_end   = fend_ff;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rffe_pkg::*;

   // protocol constants
   localparam logic [7:0]  SYNC_BYTE        = 8'hA5;
   localparam logic [15:0] CMD_GAME_STATUS  = 16'd1;
   localparam logic [15:0] CMD_ROBOT_HP     = 16'd3;
   localparam logic [15:0] CMD_WARNING      = 16'd260;
   localparam logic [15:0] CMD_ROBOT_STATUS = 16'd201;
   localparam logic [15:0] CMD_POWER_HEAT   = 16'd514;
   localparam logic [15:0] CMD_SHOOT        = 16'd519;
   localparam int          HEADER_BYTES     = 6;
   localparam int          RANDOM_BYTES     = 700;
   localparam int          QUIET_LIMIT      = 3000;
   localparam int          HOLD_CYCLES      = 250;
   localparam int          DRAIN_CYCLES     = 20;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_SYNC} fill_type;

   typedef struct packed {
      logic [3:0] len;
      logic [4:0] fid;
      kind_type   kind;
   } seg_t;

   typedef struct packed {
      logic [4:0]  fid;
      logic [31:0] value;
      logic        upd;
      logic        last;
   } field_word_t;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [4:0]  rsp_field_id;
   logic [31:0] rsp_field_value;
   logic        rsp_field_valid;
   logic        rsp_frame_end;

   logic [7:0]  pending_bytes[$];
   field_word_t expected_fields[$];

   // predictor state
   phase_type   pr_phase   = PHASE_HUNT;
   logic [2:0]  hdr_seen   = 3'd0;
   logic [15:0] cmd_id     = 16'd0;
   logic [4:0]  pay_pos    = 5'd0;
   logic [31:0] acc_value  = 32'd0;
   logic [7:0]  held_robot = 8'd0;

   int stim_total   = 0;
   int bytes_in     = 0;
   int frames_sent  = 0;
   int words_out    = 0;
   int updates_out  = 0;
   int frames_done  = 0;
   int errors       = 0;
   int quiet_cycles = 0;
   int hold_left    = 0;
   bit hold_done    = 1'b0;

   referee_frame_field_extractor DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_field_id    (rsp_field_id),
      .rsp_field_value (rsp_field_value),
      .rsp_field_valid (rsp_field_valid),
      .rsp_frame_end   (rsp_frame_end)
   );

   // payload segment layouts, all frames back to back
   function automatic seg_t seg_at(input int idx);
      seg_t s;
      case (idx)
         0:  s = {4'd1,  FID_STAGE,           KIND_STAGE};
         1:  s = {4'd2,  FID_REMAIN_TIME,     KIND_PLAIN};
         2:  s = {4'd10, FID_NONE,            KIND_SKIP};
         3:  s = {4'd2,  FID_RED_SENTRY_HP,   KIND_PLAIN};
         4:  s = {4'd14, FID_NONE,            KIND_SKIP};
         5:  s = {4'd2,  FID_BLUE_SENTRY_HP,  KIND_PLAIN};
         6:  s = {4'd1,  FID_WARNING,         KIND_WARN};
         7:  s = {4'd1,  FID_FOUL_ROBOT,      KIND_PLAIN};
         8:  s = {4'd1,  FID_ROBOT_ID,        KIND_ROBOT};
         9:  s = {4'd1,  FID_ROBOT_LEVEL,     KIND_PLAIN};
         10: s = {4'd2,  FID_ROBOT_HP,        KIND_PLAIN};
         11: s = {4'd2,  FID_NONE,            KIND_SKIP};
         12: s = {4'd2,  FID_COOLING,         KIND_PLAIN};
         13: s = {4'd2,  FID_HEAT_LIMIT,      KIND_PLAIN};
         14: s = {4'd2,  FID_SPEED_LIMIT,     KIND_PLAIN};
         15: s = {4'd2,  FID_ALT_COOLING,     KIND_SET_A};
         16: s = {4'd2,  FID_ALT_HEAT_LIMIT,  KIND_SET_A};
         17: s = {4'd2,  FID_ALT_SPEED_LIMIT, KIND_SET_A};
         18: s = {4'd2,  FID_ALT_COOLING,     KIND_SET_B};
         19: s = {4'd2,  FID_ALT_HEAT_LIMIT,  KIND_SET_B};
         20: s = {4'd2,  FID_ALT_SPEED_LIMIT, KIND_SET_B};
         21: s = {4'd2,  FID_POWER_LIMIT,     KIND_PLAIN};
         22: s = {4'd2,  FID_CHASSIS_VOLTAGE, KIND_PLAIN};
         23: s = {4'd2,  FID_CHASSIS_CURRENT, KIND_PLAIN};
         24: s = {4'd4,  FID_CHASSIS_POWER,   KIND_PLAIN};
         25: s = {4'd2,  FID_NONE,            KIND_SKIP};
         26: s = {4'd2,  FID_BARREL_HEAT,     KIND_PLAIN};
         27: s = {4'd2,  FID_ALT_BARREL_HEAT, KIND_SET_A};
         28: s = {4'd2,  FID_ALT_BARREL_HEAT, KIND_SET_B};
         29: s = {4'd1,  FID_NONE,            KIND_SKIP};
         30: s = {4'd1,  FID_LAUNCH_ID,       KIND_LAUNCH};
         31: s = {4'd1,  FID_LAUNCH_FREQ,     KIND_PLAIN};
         32: s = {4'd4,  FID_LAUNCH_SPEED,    KIND_PLAIN};
         default: s = {4'd0, FID_NONE, KIND_SKIP};
      endcase
      return s;
   endfunction

   function automatic frame_type frame_of(input logic [15:0] cmd);
      case (cmd)
         CMD_GAME_STATUS:  return FRAME_GAME_STATUS;
         CMD_ROBOT_HP:     return FRAME_ROBOT_HP;
         CMD_WARNING:      return FRAME_WARNING;
         CMD_ROBOT_STATUS: return FRAME_ROBOT_STATUS;
         CMD_POWER_HEAT:   return FRAME_POWER_HEAT;
         CMD_SHOOT:        return FRAME_SHOOT;
         default:          return FRAME_NONE;
      endcase
   endfunction

   function automatic void frame_span(input frame_type fr, output int first, output int count);
      case (fr)
         FRAME_GAME_STATUS:  begin first = 0;  count = 2;  end
         FRAME_ROBOT_HP:     begin first = 2;  count = 4;  end
         FRAME_WARNING:      begin first = 6;  count = 2;  end
         FRAME_ROBOT_STATUS: begin first = 8;  count = 14; end
         FRAME_POWER_HEAT:   begin first = 22; count = 7;  end
         FRAME_SHOOT:        begin first = 29; count = 4;  end
         default:            begin first = 0;  count = 0;  end
      endcase
   endfunction

   function automatic int frame_total(input frame_type fr);
      int   first, count, i, total;
      seg_t s;
      frame_span(fr, first, count);
      total = 0;
      for (i = 0; i < count; i++) begin
         s = seg_at(first + i);
         total += s.len;
      end
      return total;
   endfunction

   function automatic bit robot_in_set_a(input logic [7:0] id);
      return id == 8'd3 || id == 8'd4 || id == 8'd5 || id == 8'd7 ||
             id == 8'd103 || id == 8'd104 || id == 8'd105 || id == 8'd107;
   endfunction

   function automatic bit robot_in_set_b(input logic [7:0] id);
      return id == 8'd1 || id == 8'd101;
   endfunction

   // ascii code for a stage value 0..5
   function automatic logic [31:0] stage_letter(input logic [2:0] code);
      case (code)
         3'd0:    return "P";
         3'd1:    return "S";
         3'd2:    return "I";
         3'd3:    return "F";
         3'd4:    return "C";
         default: return "R";
      endcase
   endfunction

   // advance the predicted parser by one byte, queue any result word
   task automatic decode_byte(input logic [7:0] b);
      frame_type   fr;
      seg_t        s;
      field_word_t w;
      int          first, count, total, start, pos, i;
      bit          found, last;
      case (pr_phase)
         PHASE_HEADER: begin
            if (hdr_seen == 3'd4)
               cmd_id = {8'h00, b};
            else if (hdr_seen == 3'd5)
               cmd_id = {cmd_id[7:0], b};
            hdr_seen = hdr_seen + 3'd1;
            if (hdr_seen >= HEADER_BYTES) begin
               hdr_seen = 3'd0;
               pay_pos  = 5'd0;
               pr_phase = (frame_of(cmd_id) != FRAME_NONE) ? PHASE_PAYLOAD : PHASE_HUNT;
            end
         end
         PHASE_PAYLOAD: begin
            fr = frame_of(cmd_id);
            frame_span(fr, first, count);
            total = frame_total(fr);
            w     = '0;
            start = 0;
            found = 1'b0;
            for (i = 0; i < count && !found; i++) begin
               s = seg_at(first + i);
               if (pay_pos < start + s.len) begin
                  found = 1'b1;
                  pos = pay_pos - start;
                  acc_value = (pos == 0) ? {24'h0, b} : {acc_value[23:0], b};
                  if (pos + 1 == s.len) begin
                     w.fid = s.fid;
                     case (s.kind)
                        KIND_PLAIN: begin
                           w.upd = 1'b1;
                           w.value = acc_value;
                        end
                        KIND_ROBOT: begin
                           held_robot = acc_value[7:0];
                           w.upd = 1'b1;
                           w.value = acc_value;
                        end
                        KIND_STAGE: begin
                           if (acc_value[2:0] < 3'd6) begin
                              w.upd = 1'b1;
                              w.value = stage_letter(acc_value[2:0]);
                           end
                        end
                        KIND_WARN: begin
                           w.upd = 1'b1;
                           if (acc_value == 32'd1)
                              w.value = "Y";
                           else if (acc_value == 32'd2)
                              w.value = "R";
                           else if (acc_value == 32'd3)
                              w.value = "F";
                           else
                              w.upd = 1'b0;
                        end
                        KIND_LAUNCH: begin
                           if (acc_value[2:0] >= 3'd1 && acc_value[2:0] <= 3'd3) begin
                              w.upd = 1'b1;
                              w.value = {29'h0, acc_value[2:0]};
                           end
                        end
                        KIND_SET_A: begin
                           w.upd = robot_in_set_a(held_robot);
                           w.value = acc_value;
                        end
                        KIND_SET_B: begin
                           w.upd = robot_in_set_b(held_robot);
                           w.value = acc_value;
                        end
                        default: ;
                     endcase
                  end
               end
               start += s.len;
            end
            last = (pay_pos + 1 >= total);
            if (last) begin
               pr_phase = PHASE_HUNT;
               pay_pos  = 5'd0;
            end else begin
               pay_pos = pay_pos + 5'd1;
            end
            // a word without an update carries zero id and value
            if (!w.upd) begin
               w.fid = FID_NONE;
               w.value = 32'd0;
            end
            w.last = last;
            if (w.upd || last)
               expected_fields.push_back(w);
         end
         default: begin
            pr_phase = PHASE_HUNT;
            if (b == SYNC_BYTE) begin
               pr_phase = PHASE_HEADER;
               hdr_seen = 3'd0;
            end
         end
      endcase
   endtask

   // stimulus building
   function automatic logic [7:0] fill_byte(input fill_type fill);
      case (fill)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hFF;
         FILL_SYNC: return SYNC_BYTE;
         default:   return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic queue_frame(input logic [15:0] cmd, input int pay_len, input logic [7:0] key,
                              input fill_type fill);
      int i, key_pos;
      key_pos = (cmd == CMD_SHOOT) ? 1 : 0;
      pending_bytes.push_back(SYNC_BYTE);
      for (i = 0; i < 4; i++)
         pending_bytes.push_back(fill_byte(fill));
      pending_bytes.push_back(cmd[15:8]);
      pending_bytes.push_back(cmd[7:0]);
      for (i = 0; i < pay_len; i++)
         pending_bytes.push_back((i == key_pos) ? key : fill_byte(fill));
      frames_sent++;
   endtask

   task automatic queue_known(input logic [15:0] cmd, input logic [7:0] key,
                              input fill_type fill);
      queue_frame(cmd, frame_total(frame_of(cmd)), key, fill);
   endtask

   function automatic logic [15:0] pick_command();
      case ($urandom_range(5))
         0:       return CMD_GAME_STATUS;
         1:       return CMD_ROBOT_HP;
         2:       return CMD_WARNING;
         3:       return CMD_ROBOT_STATUS;
         4:       return CMD_POWER_HEAT;
         default: return CMD_SHOOT;
      endcase
   endfunction

   // key payload byte that steers the decode of each command (the first, the second for shoot)
   function automatic logic [7:0] pick_key(input logic [15:0] cmd);
      if (cmd == CMD_WARNING && $urandom_range(9) < 7)
         return 8'($urandom_range(4));
      if (cmd == CMD_ROBOT_STATUS) begin
         case ($urandom_range(12))
            0:  return 8'd1;
            1:  return 8'd3;
            2:  return 8'd4;
            3:  return 8'd5;
            4:  return 8'd7;
            5:  return 8'd101;
            6:  return 8'd103;
            7:  return 8'd104;
            8:  return 8'd105;
            9:  return 8'd107;
            10: return 8'd2;
            default: return 8'($urandom_range(255));
         endcase
      end
      return 8'($urandom_range(255));
   endfunction

   function automatic fill_type pick_fill();
      case ($urandom_range(19))
         0:       return FILL_ZERO;
         1:       return FILL_ONES;
         2:       return FILL_SYNC;
         default: return FILL_RANDOM;
      endcase
   endfunction

   // idle mix: sender light / receiver heavy, then swapped, then none
   function automatic int send_idle_pct();
      if (bytes_in < stim_total / 3) return 9;
      if (bytes_in < 2 * stim_total / 3) return 87;
      return 0;
   endfunction

   function automatic int recv_idle_pct();
      if (bytes_in < stim_total / 3) return 87;
      if (bytes_in < 2 * stim_total / 3) return 9;
      return 0;
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // input driver, one word per handshake
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            decode_byte(req_rx_byte);
            bytes_in <= bytes_in + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
               req_valid   <= 1'b1;
               req_rx_byte <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result receiver with one long hold-off late in the run
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && bytes_in >= (5 * stim_total) / 6) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct());
      end
   end

   // result monitor
   always @(posedge clock) begin
      field_word_t got, exp;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_field_id, rsp_field_value, rsp_field_valid, rsp_frame_end};
         words_out++;
         if (rsp_field_valid) updates_out++;
         if (rsp_frame_end) frames_done++;
         if (expected_fields.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word: id %0d value %h valid %b end %b",
                     $time, got.fid, got.value, got.upd, got.last);
         end else begin
            exp = expected_fields.pop_front();
            if (got !== exp) begin
               errors++;
               $display("%0t: mismatch: expected id %0d value %h valid %b end %b",
                        $time, exp.fid, exp.value, exp.upd, exp.last);
               $display("%0t: mismatch: actual   id %0d value %h valid %b end %b",
                        $time, got.fid, got.value, got.upd, got.last);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      int target, len;
      logic [15:0] cmd;

      // noise ahead of the first start byte
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(8'h5A);
      // stage codes, including the two that emit nothing
      queue_known(CMD_GAME_STATUS, 8'h00, FILL_ZERO);
      queue_known(CMD_GAME_STATUS, 8'hFD, FILL_ONES);
      queue_known(CMD_GAME_STATUS, 8'h06, FILL_RANDOM);
      queue_known(CMD_GAME_STATUS, 8'hFF, FILL_ONES);
      queue_known(CMD_ROBOT_HP, 8'h00, FILL_ZERO);
      queue_known(CMD_ROBOT_HP, 8'hFF, FILL_ONES);
      // warning codes, valid and rejected
      queue_known(CMD_WARNING, 8'd1, FILL_RANDOM);
      queue_known(CMD_WARNING, 8'd2, FILL_RANDOM);
      queue_known(CMD_WARNING, 8'd3, FILL_RANDOM);
      queue_known(CMD_WARNING, 8'd0, FILL_RANDOM);
      queue_known(CMD_WARNING, 8'hFF, FILL_ONES);
      // robot id sets steering the second weapon fields
      queue_known(CMD_ROBOT_STATUS, 8'd3, FILL_ONES);
      queue_known(CMD_POWER_HEAT, 8'h00, FILL_ZERO);
      queue_known(CMD_ROBOT_STATUS, 8'd1, FILL_ZERO);
      queue_known(CMD_POWER_HEAT, 8'hFF, FILL_ONES);
      queue_known(CMD_ROBOT_STATUS, 8'd107, FILL_RANDOM);
      queue_known(CMD_ROBOT_STATUS, 8'd101, FILL_RANDOM);
      queue_known(CMD_ROBOT_STATUS, 8'd0, FILL_RANDOM);
      queue_known(CMD_POWER_HEAT, 8'h00, FILL_RANDOM);
      // launch codes
      queue_known(CMD_SHOOT, 8'd0, FILL_ZERO);
      queue_known(CMD_SHOOT, 8'd1, FILL_RANDOM);
      queue_known(CMD_SHOOT, 8'hFB, FILL_ONES);
      queue_known(CMD_SHOOT, 8'd4, FILL_RANDOM);
      // unknown command ids drop the header
      queue_frame(16'h0102, 4, 8'h00, FILL_RANDOM);
      queue_frame(16'hFFFF, 3, 8'hFF, FILL_ONES);
      // start byte as header and payload data
      queue_known(CMD_ROBOT_HP, SYNC_BYTE, FILL_SYNC);

      // random part: mostly well-formed frames, some broken ones and noise
      target = pending_bytes.size() + RANDOM_BYTES;
      while (pending_bytes.size() < target) begin
         len = $urandom_range(99);
         if (len < 75) begin
            cmd = pick_command();
            queue_known(cmd, pick_key(cmd), pick_fill());
         end else if (len < 85) begin
            cmd = 16'($urandom_range(65535));
            while (frame_of(cmd) != FRAME_NONE)
               cmd = 16'($urandom_range(65535));
            queue_frame(cmd, $urandom_range(6), 8'($urandom_range(255)), FILL_RANDOM);
         end else if (len < 93) begin
            cmd = pick_command();
            queue_frame(cmd, $urandom_range(frame_total(frame_of(cmd)) - 1), pick_key(cmd),
                        FILL_RANDOM);
         end else begin
            repeat ($urandom_range(1, 5))
               pending_bytes.push_back(8'($urandom_range(255)));
         end
      end
      stim_total = pending_bytes.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() > 0 || req_valid || expected_fields.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d bytes in %0d queued frames, %0d result words, %0d field updates",
               bytes_in, frames_sent, words_out, updates_out);
      $display("%0d frame ends seen; idle mixes on both sides plus one long output stall",
               frames_done);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/rffe_pkg.sv
rtl/core/rffe_front.sv
rtl/core/rffe_queue.sv
rtl/core/rffe_back.sv
rtl/core/referee_frame_field_extractor.sv
tb/tb_top.sv
